[rtl/csvt_pkg.sv]
// csvt_pkg: shared types and constants of the CSV field tokenizer.
// No dependencies; imported by csvt_step, the tokenizer unit and the bench.
package csvt_pkg;

  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_FIELD  = 3'd1,
    KIND_RECORD = 3'd2,
    KIND_UNTERM = 3'd3,
    KIND_EMPTY  = 3'd4
  } token_kind_e;

  // Parser flags carried from one byte to the next
  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic cr_pending;
    logic field_begun;
    logic record_has_field;
  } csvt_state_t;

  // One token as it leaves the step logic
  typedef struct packed {
    logic [7:0]  out_byte;
    token_kind_e token_kind;
    logic        final_result;
  } csvt_result_t;

endpackage

[rtl/csvt_if.sv]
// csvt_in_if / csvt_out_if: valid/ready channels of the CSV tokenizer.
// Depends on nothing; a transaction completes when valid and ready are high.
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] token_kind;
  logic       final_result;

  modport source (output valid, output out_byte, output token_kind, output final_result,
                  input ready);
  modport sink   (input valid, input out_byte, input token_kind, input final_result,
                  output ready);
endinterface

[rtl/csvt_step.sv]
// csvt_step: next-flag and token logic for one byte or end-of-text marker.
// Pure combinational; uses csvt_pkg types.
module csvt_step (
  input  csvt_pkg::csvt_state_t  state_i,
  input  logic [7:0]             text_byte_i,
  input  logic                   end_of_text_i,
  output csvt_pkg::csvt_state_t  state_o,
  output logic                   emit_o,
  output csvt_pkg::csvt_result_t result_o
);
  import csvt_pkg::*;

  logic skip_lf;
  logic plain;

  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '{out_byte: 8'h00, token_kind: KIND_DATA, final_result: 1'b0};
    skip_lf  = 1'b0;
    plain    = 1'b0;

    if (end_of_text_i) begin
      emit_o                = 1'b1;
      result_o.final_result = 1'b1;
      if (state_i.in_quotes && !state_i.quote_pending) begin
        result_o.token_kind = KIND_UNTERM;
      end else if (state_i.record_has_field || state_i.field_begun) begin
        result_o.token_kind = KIND_RECORD;
      end else begin
        result_o.token_kind = KIND_EMPTY;
      end
      state_o = '0;
    end else begin
      // LF right after CR belongs to the same line break
      state_o.cr_pending = 1'b0;
      skip_lf = state_i.cr_pending && (text_byte_i == CharLf);

      if (!skip_lf) begin
        if (state_i.in_quotes) begin
          if (state_i.quote_pending) begin
            state_o.quote_pending = 1'b0;
            if (text_byte_i == CharQuote) begin
              emit_o            = 1'b1;
              result_o.out_byte = text_byte_i;
            end else begin
              state_o.in_quotes = 1'b0;
              plain             = 1'b1;
            end
          end else if (text_byte_i == CharQuote) begin
            state_o.quote_pending = 1'b1;
          end else begin
            emit_o            = 1'b1;
            result_o.out_byte = text_byte_i;
          end
        end else begin
          plain = 1'b1;
        end
      end

      if (plain) begin
        case (text_byte_i)
          CharQuote: begin
            if (!state_i.field_begun) begin
              state_o.in_quotes   = 1'b1;
              state_o.field_begun = 1'b1;
            end else begin
              emit_o            = 1'b1;
              result_o.out_byte = text_byte_i;
            end
          end
          CharComma: begin
            state_o.field_begun      = 1'b0;
            state_o.record_has_field = 1'b1;
            emit_o                   = 1'b1;
            result_o.token_kind      = KIND_FIELD;
          end
          CharCr, CharLf: begin
            if (text_byte_i == CharCr) begin
              state_o.cr_pending = 1'b1;
            end
            // blank line gives no token
            emit_o                   = state_i.record_has_field || state_i.field_begun;
            result_o.token_kind      = KIND_RECORD;
            state_o.field_begun      = 1'b0;
            state_o.record_has_field = 1'b0;
          end
          default: begin
            state_o.field_begun = 1'b1;
            emit_o              = 1'b1;
            result_o.out_byte   = text_byte_i;
          end
        endcase
      end
    end
  end

endmodule

[rtl/csv_field_tokenizer_unit.sv]
// A token appears on out_o in the cycle after its input transaction.
// Throughput: one byte per cycle unless out_o stalls; flag registers update in
// the same cycle the byte is taken; the result register is the only stage on
// the path. in_i.ready drops only while a held token waits on out_o.ready.
// Reset (rst_ni low, asynchronous): all parser flags clear, result register empty.
module csv_field_tokenizer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  csvt_in_if.sink           in_i,
  csvt_out_if.source        out_o
);
  import csvt_pkg::*;

  csvt_state_t  state_q, state_d;
  csvt_result_t result_q, result_d;
  csvt_result_t step_result;
  logic         step_emit;
  logic         out_valid_q, out_valid_d;
  logic         in_fire;

  // Result register frees up in the same cycle its token is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  csvt_step u_step (
    .state_i       (state_q),
    .text_byte_i   (in_i.text_byte),
    .end_of_text_i (in_i.end_of_text),
    .state_o       (state_d),
    .emit_o        (step_emit),
    .result_o      (step_result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    // not every byte makes a token (opening quote, swallowed LF, blank line)
    if (in_fire && step_emit) begin
      out_valid_d = 1'b1;
      result_d    = step_result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        state_q <= state_d;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = result_q.out_byte;
  assign out_o.token_kind   = result_q.token_kind;
  assign out_o.final_result = result_q.final_result;

`ifndef SYNTHESIS
  // a pending closing quote only exists inside a quoted field
  a_qp_in_quotes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.quote_pending |-> state_q.in_quotes)
    else $error("quote_pending set outside quotes");

  // CR can only be pending after an unquoted record end
  a_cr_unquoted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cr_pending |-> !state_q.in_quotes)
    else $error("cr_pending set inside quotes");

  // end-of-text clears every flag
  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.end_of_text |=> state_q == '0)
    else $error("flags not cleared after end of text");

  // end-of-text always yields a final token
  a_eot_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.end_of_text |=> out_valid_q && result_q.final_result)
    else $error("end of text gave no final token");

  // non-data tokens carry a zero byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.token_kind != KIND_DATA |-> result_q.out_byte == 8'h00)
    else $error("non-data token with nonzero byte");
`endif

endmodule

[tb/csv_field_tokenizer_unit_test.sv]
// csv_field_tokenizer_unit_test: self-checking bench for the CSV field tokenizer.
// Depends on csvt_pkg, csvt_in_if / csvt_out_if and csv_field_tokenizer_unit.
module csv_field_tokenizer_unit_test;
  import csvt_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int TailCycles = 4;     // result register is one stage deep

  logic clk;
  logic rst_n;

  csvt_in_if  in_if ();
  csvt_out_if out_if ();

  csv_field_tokenizer_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Parser flags of the bench's own tokenizer model
  bit quoted;        // inside a quoted field
  bit quote_held;    // quote seen inside quotes, next byte decides
  bit cr_held;       // CR ended a record, an LF right after it is dropped
  bit field_open;    // current field has content or an opening quote
  bit record_open;   // at least one field of this record has ended

  csvt_result_t token_q[$];   // tokens still to come out of the block
  csvt_result_t head_tok;
  int           mismatches;
  int           items_sent;
  int           cycles;
  bit           calm;           // when set, neither side idles

  // ---------------------------------------------------------------------------
  // Tokenizer model
  // ---------------------------------------------------------------------------

  // Byte handled outside quotes, with no lookahead left over.
  function automatic bit plain_token(input logic [7:0] c, output csvt_result_t tok);
    bit emit;
    tok.out_byte     = 8'h00;
    tok.token_kind   = KIND_DATA;
    tok.final_result = 1'b0;
    emit             = 1'b1;
    if (c == CharQuote && !field_open) begin
      // quote at the very start of a field opens a quoted field
      quoted     = 1'b1;
      field_open = 1'b1;
      emit       = 1'b0;
    end else if (c == CharComma) begin
      field_open     = 1'b0;
      record_open    = 1'b1;
      tok.token_kind = KIND_FIELD;
    end else if (c == CharCr || c == CharLf) begin
      if (c == CharCr) cr_held = 1'b1;
      // blank line: nothing ended and nothing begun, so no token
      emit           = record_open || field_open;
      tok.token_kind = KIND_RECORD;
      field_open     = 1'b0;
      record_open    = 1'b0;
    end else begin
      // mid-field quote lands here too and stays literal
      if (c != CharQuote) field_open = 1'b1;
      tok.out_byte = c;
    end
    return emit;
  endfunction

  // Next token for one input transaction; returns 0 when none is due.
  function automatic bit tokenize(input logic [7:0] c, input logic eot,
                                  output csvt_result_t tok);
    tok.out_byte     = 8'h00;
    tok.token_kind   = KIND_DATA;
    tok.final_result = 1'b0;
    if (eot) begin
      tok.final_result = 1'b1;
      if (quoted && !quote_held)       tok.token_kind = KIND_UNTERM;
      else if (record_open || field_open) tok.token_kind = KIND_RECORD;
      else                             tok.token_kind = KIND_EMPTY;
      quoted      = 1'b0;
      quote_held  = 1'b0;
      cr_held     = 1'b0;
      field_open  = 1'b0;
      record_open = 1'b0;
      return 1'b1;
    end
    if (cr_held) begin
      cr_held = 1'b0;
      if (c == CharLf) return 1'b0;   // LF of a CRLF pair
    end
    if (quoted) begin
      if (quote_held) begin
        quote_held = 1'b0;
        if (c == CharQuote) begin     // doubled quote -> one literal quote
          tok.out_byte = c;
          return 1'b1;
        end
        quoted = 1'b0;                // closing quote; byte handled outside
        return plain_token(c, tok);
      end
      if (c == CharQuote) begin
        quote_held = 1'b1;
        return 1'b0;
      end
      tok.out_byte = c;
      return 1'b1;
    end
    return plain_token(c, tok);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit, output side
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout, %0d tokens still expected", $time, token_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Output ready changes on the falling edge; it idles ~35% outside calm phases.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  // Every output transaction is checked against the oldest expected token.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (token_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected token kind %0d byte %02h", $time,
                 out_if.token_kind, out_if.out_byte);
      end else begin
        head_tok = token_q.pop_front();
        if (out_if.token_kind !== head_tok.token_kind) begin
          mismatches++;
          $display("%0t: token_kind expected %0d, actual %0d", $time,
                   head_tok.token_kind, out_if.token_kind);
        end
        if (out_if.out_byte !== head_tok.out_byte) begin
          mismatches++;
          $display("%0t: out_byte expected %02h, actual %02h", $time,
                   head_tok.out_byte, out_if.out_byte);
        end
        if (out_if.final_result !== head_tok.final_result) begin
          mismatches++;
          $display("%0t: final_result expected %0b, actual %0b", $time,
                   head_tok.final_result, out_if.final_result);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // One input transaction. Called at a falling edge; returns at the falling
  // edge after acceptance with valid still high, so back-to-back items in calm
  // phases never drop valid.
  task automatic send_item(input logic [7:0] b, input logic eot);
    csvt_result_t tok;
    while (!calm && $urandom_range(99) < 35) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.text_byte   <= b;
    in_if.end_of_text <= eot;
    do @(posedge clk); while (!in_if.ready);
    if (tokenize(b, eot, tok)) token_q.insert(token_q.size(), tok);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the input off until the block has handed over every pending token.
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    while (token_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Field content byte; plain content never carries a separator.
  function automatic logic [7:0] pick_content(input bit plain);
    logic [7:0] c;
    do begin
      case ($urandom_range(9))
        0:       c = CharQuote;
        1, 2:    c = 8'($urandom_range(255));
        default: c = 8'($urandom_range(8'h7E, 8'h20));
      endcase
    end while (plain && (c == CharComma || c == CharCr || c == CharLf));
    return c;
  endfunction

  task automatic send_field(input bit is_quoted, input int len);
    logic [7:0] c;
    if (is_quoted) send_item(CharQuote, 1'b0);
    for (int i = 0; i < len; i++) begin
      c = pick_content(!is_quoted);
      // a leading quote would open a quoted field
      if (!is_quoted && i == 0 && c == CharQuote) c = 8'h41;
      send_item(c, 1'b0);
      if (is_quoted && c == CharQuote) send_item(CharQuote, 1'b0);
    end
    if (is_quoted) send_item(CharQuote, 1'b0);
  endtask

  // One record of 1..4 fields, ended by LF, CR, CRLF or end of text.
  task automatic send_record();
    int n_fields;
    n_fields = int'($urandom_range(4, 1));
    for (int f = 0; f < n_fields; f++) begin
      if (f != 0) send_item(CharComma, 1'b0);
      send_field(1'($urandom_range(1)), int'($urandom_range(5, 0)));
    end
    case ($urandom_range(7))
      0, 1, 2: send_item(CharLf, 1'b0);
      3, 4:    send_item(CharCr, 1'b0);
      5, 6: begin
        send_item(CharCr, 1'b0);
        send_item(CharLf, 1'b0);
      end
      default: send_item(8'($urandom_range(255)), 1'b1);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and every special case, each in a known state.
  task automatic test_directed();
    send_item(8'hFF, 1'b1);        // end of text on empty input, byte ignored
    send_item(8'h00, 1'b0);        // lowest data byte
    send_item(8'hFF, 1'b0);        // highest data byte
    send_item(CharComma, 1'b0);    // field end
    send_item(CharQuote, 1'b0);    // opens quoted field
    send_item(CharQuote, 1'b0);    // pending
    send_item(CharQuote, 1'b0);    // doubled quote -> literal
    send_item(CharComma, 1'b0);    // comma inside quotes is data
    send_item(CharQuote, 1'b0);    // pending
    send_item(CharComma, 1'b0);    // closes field, then field end
    send_item(8'h61, 1'b0);
    send_item(CharQuote, 1'b0);    // quote mid-field stays literal
    send_item(CharCr, 1'b0);       // record end
    send_item(CharLf, 1'b0);       // LF of CRLF swallowed
    send_item(CharLf, 1'b0);       // blank line, no token
    send_item(CharCr, 1'b0);       // blank line, no token
    send_item(8'h62, 1'b0);        // byte right after a lone CR
    send_item(CharLf, 1'b0);
    send_item(CharQuote, 1'b0);
    send_item(8'h7A, 1'b0);
    send_item(8'h00, 1'b1);        // unterminated quote
    send_item(CharQuote, 1'b0);
    send_item(CharQuote, 1'b0);    // closing quote still pending
    send_item(8'hA5, 1'b1);        // end of text flushes the record
  endtask

  // Well-formed documents with random content; the first stretch runs with no
  // idling on either side, and the input now and then waits for a full drain.
  task automatic test_wellformed_records(input int n_items);
    int first;
    int target;
    first  = items_sent;
    target = items_sent + n_items;
    calm   = 1'b1;
    while (items_sent < target) begin
      if (items_sent > first + 150) calm = 1'b0;
      if ($urandom_range(9) == 0) send_item(CharLf, 1'b0);     // blank line
      send_record();
      if ($urandom_range(7) == 0) send_item(8'($urandom_range(255)), 1'b1);
      if ($urandom_range(39) == 0) wait_for_drain();
    end
    calm = 1'b0;
  endtask

  // Broken input: separators and quotes in any order, any byte value.
  task automatic test_noise(input int n_items);
    int pick;
    repeat (n_items) begin
      pick = int'($urandom_range(19));
      if (pick < 1)       send_item(8'($urandom_range(255)), 1'b1);
      else if (pick < 4)  send_item(CharQuote, 1'b0);
      else if (pick < 6)  send_item(CharComma, 1'b0);
      else if (pick < 8)  send_item(CharCr, 1'b0);
      else if (pick < 10) send_item(CharLf, 1'b0);
      else                send_item(8'($urandom_range(255)), 1'b0);
    end
    send_item(8'h00, 1'b1);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.text_byte    = 8'h00;
    in_if.end_of_text  = 1'b0;
    calm               = 1'b0;
    items_sent         = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    wait_for_drain();
    test_wellformed_records(850);
    wait_for_drain();
    test_noise(350);

    // all stimulus accepted; let the last tokens out
    in_if.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
